@@ rtl/mec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types, constants and the color ramp lookup for the escape-time
// color block.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;

    localparam int IN_WIDTH   = 31;
    localparam int COUNT_W    = 7;
    localparam int COLOR_BITS = 8;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0]    COUNT_LIMIT  = 7'd100;
    localparam logic [COUNT_W-1:0]    COUNT_MID    = 7'd50;
    localparam logic [COUNT_W-1:0]    MAX_ITER_RST = 7'd100;
    localparam logic [COLOR_BITS-1:0] COLOR_MAX    = 8'hFF;

    // register index decoded from paddr[2]
    localparam logic REG_MAX_ITER = 1'b0;

    // round(255 * sin(pi*j/100)) for j = 0..50
    localparam logic [COLOR_BITS-1:0] HALF_SINE [0:50] = '{
          8'd0,   8'd8,  8'd16,  8'd24,  8'd32,  8'd40,  8'd48,  8'd56,  8'd63,  8'd71,
         8'd79,  8'd86,  8'd94, 8'd101, 8'd109, 8'd116, 8'd123, 8'd130, 8'd137, 8'd143,
        8'd150, 8'd156, 8'd163, 8'd169, 8'd175, 8'd180, 8'd186, 8'd191, 8'd196, 8'd201,
        8'd206, 8'd211, 8'd215, 8'd219, 8'd223, 8'd227, 8'd231, 8'd234, 8'd237, 8'd240,
        8'd243, 8'd245, 8'd247, 8'd249, 8'd250, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255,
        8'd255
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_core_ctl;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_core_sts;

    function automatic logic [COLOR_BITS-1:0] sine_level(input logic [COUNT_W-1:0] j);
        logic [COUNT_W-1:0] k;
        logic [COUNT_W-1:0] m;
        k = (j > COUNT_LIMIT) ? COUNT_LIMIT : j;
        m = (k > COUNT_MID) ? COUNT_LIMIT - k : k;
        return HALF_SINE[m[5:0]];
    endfunction

endpackage
`default_nettype wire

@@ rtl/mec_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mec_core
// Escape-time iteration engine: one shared multiplier forms x*x, y*y and
// x*y in turn under a small sequencer, then the adder stage updates z.
// ----------------------------------------------------------------------------
module mec_core #(
    parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mec_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire mec_pkg::t_core_ctl            i_ctl,
    input  wire        [mec_pkg::COUNT_W-1:0]  i_cap,
    input  wire signed [COORD_WIDTH-1:0]       i_cx,
    input  wire signed [COORD_WIDTH-1:0]       i_cy,
    output mec_pkg::t_core_sts                 o_sts
);
    import mec_pkg::*;

    localparam int PROD_W = 2 * COORD_WIDTH - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [PROD_W:0] LIMIT = (PROD_W + 1)'(4) << FRAC_BITS;

    t_state r_state;
    t_state n_state;

    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic signed [COORD_WIDTH-1:0] r_cx;
    logic signed [COORD_WIDTH-1:0] r_cy;
    logic        [COUNT_W-1:0]     r_n;
    logic        [COUNT_W-1:0]     r_cap;
    logic        [PROD_W-1:0]      r_xx;
    logic        [PROD_W-1:0]      r_yy;
    logic signed [PROD_W:0]        r_xy;

    logic [COORD_WIDTH-1:0]   mag_x;
    logic [COORD_WIDTH-1:0]   mag_y;
    logic [COORD_WIDTH-1:0]   mul_a;
    logic [COORD_WIDTH-1:0]   mul_b;
    logic [2*COORD_WIDTH-1:0] mul_p;
    logic [PROD_W-1:0]        mul_q;
    logic                     xy_neg;
    logic [PROD_W:0]          mag_sum;
    logic                     escape;
    logic signed [SUM_W-1:0]  tx;
    logic signed [SUM_W-1:0]  ty;

    assign mag_x = r_x[COORD_WIDTH-1] ? COORD_WIDTH'(-r_x) : COORD_WIDTH'(r_x);
    assign mag_y = r_y[COORD_WIDTH-1] ? COORD_WIDTH'(-r_y) : COORD_WIDTH'(r_y);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_SQ_X: begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
            ST_SQ_Y: begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            default: begin
                mul_a = mag_x;
                mul_b = mag_y;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign mul_q  = mul_p[2*COORD_WIDTH-1:FRAC_BITS];
    assign xy_neg = r_x[COORD_WIDTH-1] ^ r_y[COORD_WIDTH-1];

    assign mag_sum = {1'b0, r_xx} + {1'b0, r_yy};
    assign escape  = (mag_sum > LIMIT) || (r_n >= r_cap);

    assign tx = $signed({2'b00, r_xx}) - $signed({2'b00, r_yy}) + SUM_W'(r_cx);
    assign ty = (SUM_W'(r_xy) <<< 1) + SUM_W'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_sts.idle  = 1'b0;
        o_sts.done  = 1'b0;
        o_sts.count = r_n;
        unique case (r_state)
            ST_IDLE: begin
                o_sts.idle = 1'b1;
                if (i_ctl.start) begin
                    n_state = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                n_state = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                n_state = ST_CROSS;
            end
            ST_CROSS: begin
                n_state = escape ? ST_DONE : ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_SQ_X;
            end
            ST_DONE: begin
                o_sts.done = 1'b1;
                if (i_ctl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    r_x   <= '0;
                    r_y   <= '0;
                    r_n   <= '0;
                    r_cx  <= i_cx;
                    r_cy  <= i_cy;
                    r_cap <= (i_cap > COUNT_LIMIT) ? COUNT_LIMIT : i_cap;
                end
            end
            ST_SQ_X: begin
                r_xx <= mul_q;
            end
            ST_SQ_Y: begin
                r_yy <= mul_q;
            end
            ST_CROSS: begin
                r_xy <= xy_neg ? -$signed({1'b0, mul_q}) : $signed({1'b0, mul_q});
            end
            ST_UPDATE: begin
                r_x <= COORD_WIDTH'(tx);
                r_y <= COORD_WIDTH'(ty);
                r_n <= r_n + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/mandelbrot_escape_color_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_top
// Escape-time iteration of one complex point with a red/green color ramp.
// ----------------------------------------------------------------------------
// One point is taken at a time. Each iteration of z = z*z + c steps
// through x*x, y*y and x*y on the single shared multiplier, then the
// update, and the escape count is capped at 100. The result sits in an
// output register, and the next point is taken as soon as the iteration
// engine has handed its result over.
module mandelbrot_escape_color_top #(
    parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mec_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // point_real [30:0], point_imag [61:31], zero [63:62]
    input  wire  [mec_pkg::S_DATA_W-1:0]      i_s_tdata,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // iteration_count [6:0], red_level [14:7], green_level [22:15], zero [23]
    output logic [mec_pkg::M_DATA_W-1:0]      o_m_tdata,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [mec_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [mec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mec_pkg::*;

    logic [COUNT_W-1:0]  r_max_iter;
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    t_core_ctl core_ctl;
    t_core_sts core_sts;

    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic                          load;
    logic [COLOR_BITS-1:0]         red;
    logic [COLOR_BITS-1:0]         green;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_ITER) begin
            r_max_iter <= pwdata[COUNT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_MAX_ITER) ? APB_DATA_W'(r_max_iter) : '0;

    // input request
    assign o_s_tready = core_sts.idle;
    assign core_ctl   = '{start: i_s_tvalid && core_sts.idle, ack: load};
    assign cx = COORD_WIDTH'($signed(i_s_tdata[IN_WIDTH-1:0]));
    assign cy = COORD_WIDTH'($signed(i_s_tdata[2*IN_WIDTH-1:IN_WIDTH]));

    mec_core #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_cap   (r_max_iter),
        .i_cx    (cx),
        .i_cy    (cy),
        .o_sts   (core_sts)
    );

    // color ramp
    assign green = sine_level(core_sts.count);
    assign red   = (core_sts.count <= COUNT_MID) ? COLOR_MAX
                 : COLOR_MAX - sine_level(core_sts.count - COUNT_MID);

    // output register
    assign load = core_sts.done && (!r_m_valid || i_m_tready);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {1'b0, green, red, core_sts.count};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
`default_nettype wire

@@ rtl/mec_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mec_checker
// Port-level checks for the escape-time color block, bound to the top level.
// ----------------------------------------------------------------------------
module mec_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_tvalid,
    input wire                             o_s_tready,
    input wire                             o_m_tvalid,
    input wire                             i_m_tready,
    input wire [mec_pkg::M_DATA_W-1:0]     o_m_tdata
);
    import mec_pkg::*;

    // count never exceeds the table range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[COUNT_W-1:0] <= COUNT_LIMIT)
        else $error("iteration count above limit");

    // red saturates in the lower half of the ramp
    a_red_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[COUNT_W-1:0] <= COUNT_MID
        |-> o_m_tdata[COUNT_W+COLOR_BITS-1:COUNT_W] == COLOR_MAX)
        else $error("red not saturated");

    // one point at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready while a point is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

endmodule

bind mandelbrot_escape_color_top mec_checker u_mec_checker (.*);
`default_nettype wire
